[design/morse_code_keyer_macros.svh]
// ----------------------------------------------------------------------------
// Morse code keyer assertion macros
// Shared concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MORSE_CODE_KEYER_MACROS_SVH
`define MORSE_CODE_KEYER_MACROS_SVH

`ifndef SYNTH

// Checked on every rising edge of clk while rst_n is high
`define MCK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked on every rising edge of clk, reset included
`define MCK_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MCK_ASSERT(label, prop, msg)
`define MCK_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

[design/mck_pkg.sv]
// ----------------------------------------------------------------------------
// Morse code keyer package
// Character classes, element patterns, segment unit codes and the lookup.
// ----------------------------------------------------------------------------
package mck_pkg;

    localparam int CHAR_W      = 8;
    localparam int UNIT_W      = 16;
    localparam int DUR_W       = 18;
    localparam int MAP_W       = 5;
    localparam int IDX_W       = 3;

    localparam logic [UNIT_W-1:0] UNIT_TICKS_RESET = 16'd150;

    // ASCII codes used by the classifier
    localparam logic [CHAR_W-1:0] ASCII_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_NINE    = 8'h39;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] ASCII_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] ASCII_CASE    = 8'h20;

    // Segment length codes, in units
    localparam logic [1:0] UNITS_ONE   = 2'd0;
    localparam logic [1:0] UNITS_THREE = 2'd1;
    localparam logic [1:0] UNITS_FOUR  = 2'd2;

    // First element sits at the MSB of the dash map
    localparam logic [IDX_W-1:0] MAP_MSB = 3'd4;

    // One classified character as queued between front and back
    typedef struct packed {
        logic             is_space;
        logic [IDX_W-1:0] elem_count;   // 1..5 elements
        logic [MAP_W-1:0] dash_map;     // 1 = dash, element 0 at MSB
    } mck_entry_t;

    typedef struct packed {
        logic       keep;               // 0 = code produces no segments
        mck_entry_t entry;
    } mck_class_t;

    // Fold case and look up the Morse pattern of one character
    function automatic mck_class_t mck_classify(input logic [CHAR_W-1:0] code);
        logic [CHAR_W-1:0] c;
        mck_class_t        r;
        c = code;
        if (code >= ASCII_LOWER_A && code <= ASCII_LOWER_Z) begin
            c = code - ASCII_CASE;
        end
        r.keep             = 1'b1;
        r.entry.is_space   = 1'b0;
        r.entry.elem_count = 3'd1;
        r.entry.dash_map   = 5'b00000;
        case (c)
            8'h41: begin r.entry.elem_count = 3'd2; r.entry.dash_map = 5'b01000; end // A
            8'h42: begin r.entry.elem_count = 3'd4; r.entry.dash_map = 5'b10000; end // B
            8'h43: begin r.entry.elem_count = 3'd4; r.entry.dash_map = 5'b10100; end // C
            8'h44: begin r.entry.elem_count = 3'd3; r.entry.dash_map = 5'b10000; end // D
            8'h45: begin r.entry.elem_count = 3'd1; r.entry.dash_map = 5'b00000; end // E
            8'h46: begin r.entry.elem_count = 3'd4; r.entry.dash_map = 5'b00100; end // F
            8'h47: begin r.entry.elem_count = 3'd3; r.entry.dash_map = 5'b11000; end // G
            8'h48: begin r.entry.elem_count = 3'd4; r.entry.dash_map = 5'b00000; end // H
            8'h49: begin r.entry.elem_count = 3'd2; r.entry.dash_map = 5'b00000; end // I
            8'h4A: begin r.entry.elem_count = 3'd4; r.entry.dash_map = 5'b01110; end // J
            8'h4B: begin r.entry.elem_count = 3'd3; r.entry.dash_map = 5'b10100; end // K
            8'h4C: begin r.entry.elem_count = 3'd4; r.entry.dash_map = 5'b01000; end // L
            8'h4D: begin r.entry.elem_count = 3'd2; r.entry.dash_map = 5'b11000; end // M
            8'h4E: begin r.entry.elem_count = 3'd2; r.entry.dash_map = 5'b10000; end // N
            8'h4F: begin r.entry.elem_count = 3'd3; r.entry.dash_map = 5'b11100; end // O
            8'h50: begin r.entry.elem_count = 3'd4; r.entry.dash_map = 5'b01100; end // P
            8'h51: begin r.entry.elem_count = 3'd4; r.entry.dash_map = 5'b11010; end // Q
            8'h52: begin r.entry.elem_count = 3'd3; r.entry.dash_map = 5'b01000; end // R
            8'h53: begin r.entry.elem_count = 3'd3; r.entry.dash_map = 5'b00000; end // S
            8'h54: begin r.entry.elem_count = 3'd1; r.entry.dash_map = 5'b10000; end // T
            8'h55: begin r.entry.elem_count = 3'd3; r.entry.dash_map = 5'b00100; end // U
            8'h56: begin r.entry.elem_count = 3'd4; r.entry.dash_map = 5'b00010; end // V
            8'h57: begin r.entry.elem_count = 3'd3; r.entry.dash_map = 5'b01100; end // W
            8'h58: begin r.entry.elem_count = 3'd4; r.entry.dash_map = 5'b10010; end // X
            8'h59: begin r.entry.elem_count = 3'd4; r.entry.dash_map = 5'b10110; end // Y
            8'h5A: begin r.entry.elem_count = 3'd4; r.entry.dash_map = 5'b11000; end // Z
            8'h30: begin r.entry.elem_count = 3'd5; r.entry.dash_map = 5'b11111; end // 0
            8'h31: begin r.entry.elem_count = 3'd5; r.entry.dash_map = 5'b01111; end // 1
            8'h32: begin r.entry.elem_count = 3'd5; r.entry.dash_map = 5'b00111; end // 2
            8'h33: begin r.entry.elem_count = 3'd5; r.entry.dash_map = 5'b00011; end // 3
            8'h34: begin r.entry.elem_count = 3'd5; r.entry.dash_map = 5'b00001; end // 4
            8'h35: begin r.entry.elem_count = 3'd5; r.entry.dash_map = 5'b00000; end // 5
            8'h36: begin r.entry.elem_count = 3'd5; r.entry.dash_map = 5'b10000; end // 6
            8'h37: begin r.entry.elem_count = 3'd5; r.entry.dash_map = 5'b11000; end // 7
            8'h38: begin r.entry.elem_count = 3'd5; r.entry.dash_map = 5'b11100; end // 8
            8'h39: begin r.entry.elem_count = 3'd5; r.entry.dash_map = 5'b11110; end // 9
            ASCII_SPACE: begin
                r.entry.is_space = 1'b1;
            end
            default: begin
                r.keep = 1'b0;
            end
        endcase
        return r;
    endfunction

endpackage

[design/mck_front.sv]
// ----------------------------------------------------------------------------
// Morse code keyer front end
// Accepts characters, classifies them and pushes keyable ones to the queue.
// ----------------------------------------------------------------------------
module mck_front (
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [mck_pkg::CHAR_W-1:0] char_code,
    input  logic                       queue_full,
    output logic                       push,
    output mck_pkg::mck_entry_t        push_data
);
    import mck_pkg::*;

    mck_class_t char_class;

    // Table lookup of the incoming character
    assign char_class = mck_classify(char_code);

    // Hold off input while the queue has no room; unknown codes are dropped
    assign in_stall  = queue_full;
    assign push      = in_valid && !queue_full && char_class.keep;
    assign push_data = char_class.entry;

endmodule

[design/mck_queue.sv]
// ----------------------------------------------------------------------------
// Morse code keyer entry queue
// Small register FIFO between the front end and the segment sequencer.
// ----------------------------------------------------------------------------
`include "morse_code_keyer_macros.svh"

module mck_queue #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  mck_pkg::mck_entry_t wr_data,
    output logic                full,
    input  logic                rd_en,
    output logic                rd_valid,
    output mck_pkg::mck_entry_t rd_data
);
    import mck_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mck_entry_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_wr;
    logic             do_rd;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    // Pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    `MCK_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH), "queue count above depth")
    `MCK_ASSERT(a_no_push_full, !(wr_en && full), "push into a full queue")

endmodule

[design/mck_back.sv]
// ----------------------------------------------------------------------------
// Morse code keyer back end
// Steps through queued patterns and emits one keying segment per transfer.
// ----------------------------------------------------------------------------
`include "morse_code_keyer_macros.svh"

module mck_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [mck_pkg::UNIT_W-1:0] cfg_wr_data,
    input  logic                       queue_valid,
    input  mck_pkg::mck_entry_t        queue_data,
    output logic                       queue_pop,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       key_on,
    output logic [mck_pkg::DUR_W-1:0]  duration,
    output logic                       last_segment
);
    import mck_pkg::*;

    logic [UNIT_W-1:0] unit_ticks_reg;
    logic              busy_reg;
    logic              busy_next;
    mck_entry_t        entry_reg;
    mck_entry_t        entry_next;
    logic [IDX_W-1:0]  elem_idx_reg;
    logic [IDX_W-1:0]  elem_idx_next;
    logic              gap_reg;
    logic              gap_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              key_on_reg;
    logic [DUR_W-1:0]  duration_reg;
    logic              last_reg;

    logic              seg_ready;
    logic              advance;
    logic              seg_on;
    logic [1:0]        seg_units;
    logic              seg_last;
    logic              last_elem;
    logic              finishing;
    logic [DUR_W-1:0]  seg_dur;

    // Unit length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_ticks_reg <= UNIT_TICKS_RESET;
        end
        else if (cfg_wr_en)
        begin
            unit_ticks_reg <= cfg_wr_data;
        end
    end

    // Current segment from pattern, element index and phase
    assign last_elem = (elem_idx_reg == entry_reg.elem_count - 3'd1);

    always_comb
    begin
        if (entry_reg.is_space)
        begin
            seg_on    = 1'b0;
            seg_units = UNITS_FOUR;
            seg_last  = 1'b1;
        end
        else if (!gap_reg)
        begin
            seg_on    = 1'b1;
            seg_units = entry_reg.dash_map[MAP_MSB - elem_idx_reg] ? UNITS_THREE : UNITS_ONE;
            seg_last  = 1'b0;
        end
        else
        begin
            seg_on    = 1'b0;
            seg_units = last_elem ? UNITS_THREE : UNITS_ONE;
            seg_last  = last_elem;
        end
    end

    // Length in ticks: 1, 3 or 4 units by shift and add
    always_comb
    begin
        case (seg_units)
            UNITS_ONE:   seg_dur = {2'b00, unit_ticks_reg};
            UNITS_THREE: seg_dur = {2'b00, unit_ticks_reg} + {1'b0, unit_ticks_reg, 1'b0};
            UNITS_FOUR:  seg_dur = {unit_ticks_reg, 2'b00};
            default:     seg_dur = '0;
        endcase
    end

    // Sequencer control
    assign seg_ready = !out_valid_reg || !out_stall;
    assign advance   = busy_reg && seg_ready;
    assign finishing = advance && seg_last;
    assign queue_pop = queue_valid && (!busy_reg || finishing);

    always_comb
    begin
        busy_next     = busy_reg;
        entry_next    = entry_reg;
        elem_idx_next = elem_idx_reg;
        gap_next      = gap_reg;
        if (queue_pop)
        begin
            busy_next     = 1'b1;
            entry_next    = queue_data;
            elem_idx_next = '0;
            gap_next      = 1'b0;
        end
        else if (finishing)
        begin
            busy_next = 1'b0;
            gap_next  = 1'b0;
        end
        else if (advance)
        begin
            if (gap_reg)
            begin
                gap_next      = 1'b0;
                elem_idx_next = elem_idx_reg + 3'd1;
            end
            else
            begin
                gap_next = 1'b1;
            end
        end
    end

    assign out_valid_next = seg_ready ? advance : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            elem_idx_reg  <= '0;
            gap_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            elem_idx_reg  <= elem_idx_next;
            gap_reg       <= gap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Pattern and output payload
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        if (advance)
        begin
            key_on_reg   <= seg_on;
            duration_reg <= seg_dur;
            last_reg     <= seg_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign key_on       = key_on_reg;
    assign duration     = duration_reg;
    assign last_segment = last_reg;

    `MCK_ASSERT(a_on_not_last, (out_valid_reg && key_on_reg) |-> !last_reg, "on segment ends char")
    `MCK_ASSERT_ALWAYS(a_gap_busy, !rst_n || !gap_reg || busy_reg, "gap phase while idle")
    `MCK_ASSERT(a_idx_range, busy_reg |-> (elem_idx_reg < entry_reg.elem_count), "index range")

endmodule

[design/morse_code_keyer.sv]
// ----------------------------------------------------------------------------
// Morse code keyer
// ASCII character in, Morse keying segments (level and length in ticks) out.
// ----------------------------------------------------------------------------
// A character is taken and queued (QUEUE_DEPTH entries) unless its code is
// not a letter, digit or space, in which case it is dropped with no output.
// The segment sequencer then delivers one segment per cycle while out_stall
// is low: a character with n Morse elements gives 2n segments (at most ten,
// for a digit), a space gives one 4-unit off segment. Segment lengths are 1,
// 3 or 4 times the unit length, formed by shift and add from the unit
// register. Sustained rate is therefore set by the sequencer's output, one
// segment per cycle when not stalled; input is held off only on a full queue.
// ----------------------------------------------------------------------------
module morse_code_keyer #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [mck_pkg::UNIT_W-1:0] cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [mck_pkg::CHAR_W-1:0] char_code,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       key_on,
    output logic [mck_pkg::DUR_W-1:0]  duration,
    output logic                       last_segment
);
    import mck_pkg::*;

    logic       queue_full;
    logic       push;
    mck_entry_t push_data;
    logic       queue_pop;
    logic       queue_valid;
    mck_entry_t queue_data;

    // Character classification
    mck_front u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_code  (char_code),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    // Pattern queue
    mck_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push),
        .wr_data  (push_data),
        .full     (queue_full),
        .rd_en    (queue_pop),
        .rd_valid (queue_valid),
        .rd_data  (queue_data)
    );

    // Segment sequencer
    mck_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .queue_valid  (queue_valid),
        .queue_data   (queue_data),
        .queue_pop    (queue_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .key_on       (key_on),
        .duration     (duration),
        .last_segment (last_segment)
    );

endmodule
